// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the ordered list block.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OLDB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ordered list assertion failed");
`define OLDB_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("ordered list forbidden condition seen");
`else
`define OLDB_ASSERT(lbl, prop)
`define OLDB_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/core/oldb_pkg.sv =====
// Package for the ordered list block: operation and status codes, controller
// states and the command and status structs between controller and datapath.
`default_nettype none
package oldb_pkg;

	localparam int ID_W = 16;

	typedef enum logic [1:0] {
		FN_APPEND = 2'd0,
		FN_DELETE = 2'd1,
		FN_LIST   = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_REF_FIRST = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEL_HEAD,
		S_DEL_SCAN,
		S_DEL_SHIFT,
		S_LIST_PUT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic    cap_ref;
		logic    rd_en;
		logic    rd_first;
		logic    wr_append;
		logic    wr_shift;
		logic    idx_clr;
		logic    idx_inc;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    cap_head;
		logic    cap_prev;
		logic    res_set;
		status_t res_status;
		logic    res_use_prev;
		logic    out_res;
		logic    out_list;
	} dp_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic full;
		logic match;
		logic head_match;
		logic next_end;
		logic out_free;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/oldb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module oldb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/oldb_dp.sv =====
// Datapath of the ordered list block: entry count, walk index, reference and
// head registers, the ID memory and the output register. Uses oldb_pkg, oldb_ram.
`default_nettype none
module oldb_dp
	import oldb_pkg::*;
#(
	parameter int DEPTH   = 16,
	parameter int ID_BITS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire dp_cmd_t        cmd,
	output dp_sts_t             sts,
	input  wire logic [15:0]    entry_id,
	input  wire logic           out_stall,
	output logic                out_valid,
	output logic [2:0]          status,
	output logic [15:0]         result_id,
	output logic [4:0]          entry_count,
	output logic                last
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]      cnt_q;
	logic [AW-1:0]      idx_q;
	logic [ID_BITS-1:0] ref_q;
	logic [ID_BITS-1:0] head_q;
	logic [ID_BITS-1:0] prev_q;
	status_t            res_status_q;
	logic [ID_BITS-1:0] res_id_q;
	logic               out_valid_q;
	status_t            status_q;
	logic [15:0]        result_id_q;
	logic [4:0]         entry_count_q;
	logic               last_q;

	logic [ID_BITS-1:0] in_id;
	logic [ID_BITS-1:0] rd_data;
	logic [15:0]        rd_id16;
	logic [15:0]        res_id16;
	logic [CW-1:0]      idx_ext;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic [ID_BITS-1:0] wr_data;

	always_comb begin
		in_id    = '0;
		rd_id16  = '0;
		res_id16 = '0;
		for (int b = 0; b < ID_BITS && b < ID_W; b++) begin
			in_id[b]    = entry_id[b];
			rd_id16[b]  = rd_data[b];
			res_id16[b] = res_id_q[b];
		end
	end

	assign idx_ext = CW'(idx_q) + CW'(1);
	assign rd_addr = cmd.rd_first ? '0 : AW'(idx_ext);
	assign wr_addr = cmd.wr_append ? AW'(cnt_q) : idx_q - AW'(1);
	assign wr_data = cmd.wr_append ? in_id : rd_data;

	oldb_ram #(
		.WIDTH(ID_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.wr_append | cmd.wr_shift),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign sts.cnt_zero   = (cnt_q == '0);
	assign sts.full       = (cnt_q == CW'(DEPTH));
	assign sts.match      = (rd_data == ref_q);
	assign sts.head_match = (head_q == ref_q);
	assign sts.next_end   = (idx_ext >= cnt_q);
	assign sts.out_free   = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= AW'(idx_ext);
			end
			if (cmd.out_res || cmd.out_list) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_ref) begin
			ref_q <= in_id;
		end
		if (cmd.cap_head) begin
			head_q <= rd_data;
			prev_q <= rd_data;
		end else if (cmd.cap_prev) begin
			prev_q <= rd_data;
		end
		if (cmd.res_set) begin
			res_status_q <= cmd.res_status;
			res_id_q     <= cmd.res_use_prev ? prev_q : '0;
		end
		if (cmd.out_res) begin
			status_q      <= res_status_q;
			result_id_q   <= res_id16;
			entry_count_q <= 5'(cnt_q);
			last_q        <= 1'b1;
		end else if (cmd.out_list) begin
			status_q      <= ST_OK;
			result_id_q   <= rd_id16;
			entry_count_q <= 5'(cnt_q);
			last_q        <= sts.next_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign result_id   = result_id_q;
	assign entry_count = entry_count_q;
	assign last        = last_q;

endmodule
`default_nettype wire

// ===== rtl/core/oldb_ctrl.sv =====
// Controller state machine of the ordered list block. Sequences memory walks
// for delete-before and list-out and issues commands to oldb_dp. Uses oldb_pkg.
`default_nettype none
module oldb_ctrl
	import oldb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] func,
	input  wire dp_sts_t    sts,
	output dp_cmd_t         cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.res_status = ST_OK;
		in_stall       = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.cap_ref = 1'b1;
					case (func_t'(func))
						FN_APPEND: begin
							cmd.res_set = 1'b1;
							if (sts.full) begin
								cmd.res_status = ST_FULL;
							end else begin
								cmd.wr_append = 1'b1;
								cmd.cnt_inc   = 1'b1;
							end
							state_d = S_RESP;
						end
						FN_DELETE, FN_LIST: begin
							if (sts.cnt_zero) begin
								cmd.res_set    = 1'b1;
								cmd.res_status = ST_EMPTY;
								state_d        = S_RESP;
							end else begin
								cmd.rd_en    = 1'b1;
								cmd.rd_first = 1'b1;
								cmd.idx_clr  = 1'b1;
								state_d = (func_t'(func) == FN_LIST) ? S_LIST_PUT : S_DEL_HEAD;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_DEL_HEAD: begin
				cmd.cap_head = 1'b1;
				if (sts.next_end) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = ST_NOT_FOUND;
					state_d        = S_RESP;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.idx_inc = 1'b1;
					state_d     = S_DEL_SCAN;
				end
			end
			S_DEL_SCAN: begin
				if (sts.match) begin
					cmd.res_set = 1'b1;
					if (sts.head_match) begin
						cmd.res_status = ST_REF_FIRST;
						state_d        = S_RESP;
					end else begin
						cmd.res_use_prev = 1'b1;
						cmd.wr_shift     = 1'b1;
						if (sts.next_end) begin
							cmd.cnt_dec = 1'b1;
							state_d     = S_RESP;
						end else begin
							cmd.rd_en   = 1'b1;
							cmd.idx_inc = 1'b1;
							state_d     = S_DEL_SHIFT;
						end
					end
				end else begin
					cmd.cap_prev = 1'b1;
					if (sts.next_end) begin
						cmd.res_set    = 1'b1;
						cmd.res_status = ST_NOT_FOUND;
						state_d        = S_RESP;
					end else begin
						cmd.rd_en   = 1'b1;
						cmd.idx_inc = 1'b1;
					end
				end
			end
			S_DEL_SHIFT: begin
				cmd.wr_shift = 1'b1;
				if (sts.next_end) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_RESP;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.idx_inc = 1'b1;
				end
			end
			S_LIST_PUT: begin
				if (sts.out_free) begin
					cmd.out_list = 1'b1;
					if (sts.next_end) begin
						state_d = S_IDLE;
					end else begin
						cmd.rd_en   = 1'b1;
						cmd.idx_inc = 1'b1;
					end
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_res = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/ordered_list_delete_before.sv =====
// Ordered store of up to DEPTH entry IDs with append, delete-before and
// list-out. One item is handled at a time: delete-before walks the ID memory
// one entry per cycle (search, then close-up), and list-out gives one result
// per cycle for the stored entries while the output is not stalled. The
// single-port-read ID memory sets this pace. Results wait in an output
// register; the input is stalled until an item is finished.
// Uses oldb_pkg, oldb_ctrl, oldb_dp and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ordered_list_delete_before
	import oldb_pkg::*;
#(
	parameter int DEPTH   = 16,
	parameter int ID_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [15:0] entry_id,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [15:0]      result_id,
	output logic [4:0]       entry_count,
	output logic             last
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	oldb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func    (func),
		.sts     (sts),
		.cmd     (cmd)
	);

	oldb_dp #(
		.DEPTH  (DEPTH),
		.ID_BITS(ID_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.entry_id   (entry_id),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.status     (status),
		.result_id  (result_id),
		.entry_count(entry_count),
		.last       (last)
	);

	`OLDB_ASSERT(a_list_blocks_input, (out_valid && !last) |-> in_stall)
	`OLDB_ASSERT(a_full_count, (out_valid && status == ST_FULL) |-> (entry_count == 5'(DEPTH)))
	`OLDB_ASSERT(a_error_is_last, (out_valid && status != ST_OK) |-> last)
	`OLDB_ASSERT(a_empty_zero, (out_valid && status == ST_EMPTY) |-> (entry_count == '0 && result_id == '0))

endmodule
`default_nettype wire

// ===== verif/oldb_tb_pkg.sv =====
// Scoreboard for the ordered list testbench: a private copy of the stored IDs,
// the transfers each accepted request should cause, and the check of each one.
// Depends on oldb_pkg for the operation and status codes.
package oldb_tb_pkg;
	import oldb_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam logic [1:0] FN_UNUSED = 2'd3;

	typedef struct {
		status_t     status;
		logic [15:0] id;
		logic [4:0]  count;
		logic        last;
	} list_result_t;

	class id_list_scoreboard;
		logic [15:0]  model_ids [LIST_DEPTH];
		int           model_count;
		list_result_t pending_results [$];
		int           mismatches;

		function new();
			model_count = 0;
			mismatches = 0;
		endfunction

		function void push_result(status_t st, logic [15:0] id, logic last_flag);
			list_result_t r;
			r.status = st;
			r.id = id;
			r.count = model_count[4:0];
			r.last = last_flag;
			pending_results.push_back(r);
		endfunction

		function void take_request(logic [1:0] op, logic [15:0] ref_id);
			int          i;
			int          hit;
			logic [15:0] removed;
			hit = 0;
			case (op)
			FN_APPEND: begin
				if (model_count >= LIST_DEPTH) begin
					push_result(ST_FULL, 16'h0000, 1'b1);
				end else begin
					model_ids[model_count] = ref_id;
					model_count++;
					push_result(ST_OK, 16'h0000, 1'b1);
				end
			end
			FN_DELETE: begin
				// The head is skipped by the search and only compared after a hit.
				for (i = 1; i < model_count && hit == 0; i++)
					if (model_ids[i] == ref_id)
						hit = i;
				if (model_count == 0) begin
					push_result(ST_EMPTY, 16'h0000, 1'b1);
				end else if (hit == 0) begin
					push_result(ST_NOT_FOUND, 16'h0000, 1'b1);
				end else if (model_ids[0] == ref_id) begin
					push_result(ST_REF_FIRST, 16'h0000, 1'b1);
				end else begin
					removed = model_ids[hit - 1];
					for (i = hit - 1; i < model_count - 1; i++)
						model_ids[i] = model_ids[i + 1];
					model_count--;
					push_result(ST_OK, removed, 1'b1);
				end
			end
			FN_LIST: begin
				if (model_count == 0) begin
					push_result(ST_EMPTY, 16'h0000, 1'b1);
				end else begin
					for (i = 0; i < model_count; i++)
						push_result(ST_OK, model_ids[i], i == model_count - 1);
				end
			end
			default: begin
			end
			endcase
		endfunction

		function void check_result(logic [2:0] st, logic [15:0] id, logic [4:0] cnt,
				logic last_flag);
			list_result_t want;
			if (pending_results.size() == 0) begin
				$error("unexpected result transfer: status %0d, result_id %h", st, id);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (st !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, st);
				mismatches++;
			end
			if (id !== want.id) begin
				$error("result_id: expected %h, actual %h", want.id, id);
				mismatches++;
			end
			if (cnt !== want.count) begin
				$error("entry_count: expected %0d, actual %0d", want.count, cnt);
				mismatches++;
			end
			if (last_flag !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, last_flag);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

endpackage

// ===== verif/tb_ordered_list_delete_before.sv =====
// Testbench for ordered_list_delete_before: directed and random requests with
// random gaps and output stalls, checked against the scoreboard in oldb_tb_pkg.
// Depends on oldb_pkg, oldb_tb_pkg and the block's RTL.
module tb_ordered_list_delete_before;
	import oldb_pkg::*;
	import oldb_tb_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RANDOM_ITEMS = 340;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  func;
	logic [15:0] entry_id;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [15:0] result_id;
	logic [4:0]  entry_count;
	logic        last;

	id_list_scoreboard list_sb;
	int burst_left;
	bit long_hold_req;
	int cycles = 0;

	ordered_list_delete_before dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.entry_id    (entry_id),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.result_id   (result_id),
		.entry_count (entry_count),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			list_sb.check_result(status, result_id, entry_count, last);
	end

	initial begin : receiver
		int mode;
		int stretch;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			stretch = $urandom_range(10, 60);
			repeat (stretch) begin
				@(negedge clk);
				if (long_hold_req) begin
					// Hold off long enough for the block to fill and stall its input.
					out_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(negedge clk);
					long_hold_req = 1'b0;
				end
				case (mode)
				0: begin
					out_stall <= 1'b0;
				end
				1: begin
					out_stall <= ($urandom_range(0, 2) == 0);
				end
				default: begin
					out_stall <= ~out_stall;
				end
				endcase
			end
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [15:0] id);
		func <= op;
		entry_id <= id;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		list_sb.take_request(op, id);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(0, 12);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (list_sb.outstanding() != 0);
	endtask

	function automatic logic [1:0] pick_op();
		int n;
		int r;
		n = list_sb.model_count;
		r = $urandom_range(0, 99);
		if (r < 5)
			return FN_UNUSED;
		if (n < 4)
			return (r < 65) ? FN_APPEND : (r < 88) ? FN_DELETE : FN_LIST;
		if (n >= LIST_DEPTH)
			return (r < 25) ? FN_APPEND : (r < 85) ? FN_DELETE : FN_LIST;
		return (r < 47) ? FN_APPEND : (r < 88) ? FN_DELETE : FN_LIST;
	endfunction

	// IDs come from a small pool, from the store itself, or from the full range,
	// so that duplicates and reference hits are frequent.
	function automatic logic [15:0] pick_id(logic [1:0] op);
		int n;
		int r;
		n = list_sb.model_count;
		r = $urandom_range(0, 99);
		if (r < 35)
			return $urandom_range(0, 1) ? 16'($urandom_range(0, 3))
				: (16'hFFFC | 16'($urandom_range(0, 3)));
		if (r < 75 && n > 0) begin
			if (op == FN_DELETE && n > 1 && r < 68)
				return list_sb.model_ids[$urandom_range(1, n - 1)];
			return list_sb.model_ids[$urandom_range(0, n - 1)];
		end
		return 16'($urandom_range(0, 65535));
	endfunction

	initial begin : stimulus
		int k;
		int done;
		logic [1:0] op;
		in_valid = 1'b0;
		func = FN_APPEND;
		entry_id = 16'h0000;
		arst_n = 1'b0;
		burst_left = 0;
		long_hold_req = 1'b0;
		list_sb = new();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(FN_LIST, 16'h0000);
		send_item(FN_DELETE, 16'h0000);
		send_item(FN_APPEND, 16'hFFFF);
		send_item(FN_DELETE, 16'hFFFF);
		send_item(FN_APPEND, 16'h0000);
		send_item(FN_APPEND, 16'hFFFF);
		send_item(FN_DELETE, 16'hFFFF);
		send_item(FN_DELETE, 16'h5555);
		send_item(FN_DELETE, 16'h0000);
		send_item(FN_UNUSED, 16'hAAAA);
		for (k = 1; k <= 14; k++)
			send_item(FN_APPEND, 16'(16'h1111 * k));
		send_item(FN_APPEND, 16'h5A5A);
		send_item(FN_LIST, 16'h0000);
		send_item(FN_DELETE, 16'hEEEE);
		wait_drained();

		done = 0;
		while (done < RANDOM_ITEMS) begin
			op = pick_op();
			if (done == 120 && op != FN_UNUSED)
				long_hold_req = 1'b1;
			if (done == 250 && op != FN_UNUSED)
				wait_drained();
			send_item(op, pick_id(op));
			if (op != FN_UNUSED)
				done++;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (list_sb.mismatches == 0 && list_sb.outstanding() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
